FILE: src/minimum_spanning_tree_kruskal_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Kruskal spanning tree block
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MINIMUM_SPANNING_TREE_KRUSKAL_ASSERT_SVH
`define MINIMUM_SPANNING_TREE_KRUSKAL_ASSERT_SVH
`ifndef SYNTHESIS
`define MSTK_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mstk assertion failed");
`define MSTK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mstk assertion failed");
`else
`define MSTK_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define MSTK_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: src/mstk_pkg.sv
// ----------------------------------------------------------------------------
// mstk_pkg
// Shared constants and types of the Kruskal spanning tree block.
// ----------------------------------------------------------------------------
`default_nettype none

package mstk_pkg;

    localparam int MAX_VERTICES = 32;
    localparam int MAX_EDGES    = 64;
    localparam int WEIGHT_BITS  = 16;

    localparam int VTX_W  = $clog2(MAX_VERTICES);
    localparam int EIDX_W = $clog2(MAX_EDGES);
    localparam int ECNT_W = $clog2(MAX_EDGES + 1);
    localparam int N_W    = $clog2(MAX_VERTICES + 1);
    localparam int VC_W   = 6;

    localparam logic [VC_W-1:0] VC_RESET = VC_W'(32);

    typedef struct packed {
        logic [VTX_W-1:0]              src;
        logic [VTX_W-1:0]              dst;
        logic signed [WEIGHT_BITS-1:0] w;
    } t_edge;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_INIT   = 8'b0000_0010,
        S_CHECK  = 8'b0000_0100,
        S_SCAN   = 8'b0000_1000,
        S_FIND_A = 8'b0001_0000,
        S_FIND_B = 8'b0010_0000,
        S_JOIN   = 8'b0100_0000,
        S_FINISH = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic load_en;
        logic run_init;
        logic scan_start;
        logic scan_run;
        logic take_best;
        logic walk;
        logic switch_b;
        logic join_sets;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic found;
        logic at_root;
        logic roots_differ;
        logic tree_full;
        logic hold_valid;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

FILE: src/minimum_spanning_tree_kruskal.sv
// Kruskal minimum spanning tree block.
// Edges arrive on the input channel (i_valid / o_stall), one word per edge.
// A word is accepted at a rising edge with i_valid high and o_stall low,
// and words are taken back to back while idle. The word with i_last_edge
// set is stored like the others and starts a run, during which o_stall
// stays high. The run repeatedly scans the edge store for the next edge in
// ascending weight order (ties in arrival order) over the single read port
// of the edge store, then walks both parent chains of the union-find one
// step per cycle. Each chosen edge leaves as one word on the output channel
// (o_valid / i_stall); the final word carries o_last_result with the
// spanning and dropped flags, and an empty tree gives one word with
// o_edge_present low. The output register holds its word while i_stall is
// high, and the run waits for it. Reset clears the edge count, flags and
// output valid; vertex_count returns to 32. The user must see that
// vertex_count is written over the APB port at address 0 only while the
// block is idle; the block itself does not enforce this.
`default_nettype none

`include "minimum_spanning_tree_kruskal_assert.svh"

// ----------------------------------------------------------------------------
// minimum_spanning_tree_kruskal
// Top level: configuration register, controller and datapath.
// ----------------------------------------------------------------------------
module minimum_spanning_tree_kruskal (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_valid,
    output logic                                         o_stall,
    input  wire logic [mstk_pkg::VTX_W-1:0]              i_src_vertex,
    input  wire logic [mstk_pkg::VTX_W-1:0]              i_dst_vertex,
    input  wire logic signed [mstk_pkg::WEIGHT_BITS-1:0] i_edge_weight,
    input  wire logic                                    i_last_edge,
    output logic                                         o_valid,
    input  wire logic                                    i_stall,
    output logic [mstk_pkg::VTX_W-1:0]                   o_out_src_vertex,
    output logic [mstk_pkg::VTX_W-1:0]                   o_out_dst_vertex,
    output logic signed [mstk_pkg::WEIGHT_BITS-1:0]      o_out_weight,
    output logic                                         o_edge_present,
    output logic                                         o_last_result,
    output logic                                         o_spanning,
    output logic                                         o_edges_dropped,
    input  wire logic                                    psel,
    input  wire logic                                    penable,
    input  wire logic                                    pwrite,
    input  wire logic [2:0]                              paddr,
    input  wire logic [31:0]                             pwdata,
    output logic [31:0]                                  prdata,
    output logic                                         pready
);

    // The only register, vertex_count, is decoded wherever paddr[2] is low.
    logic [mstk_pkg::VC_W-1:0] r_vertex_count;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? 32'(r_vertex_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= mstk_pkg::VC_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
            r_vertex_count <= pwdata[mstk_pkg::VC_W-1:0];
        end
    end

    mstk_pkg::t_cmd    w_cmd;
    mstk_pkg::t_status w_status;
    logic              w_idle;

    // Input words are taken only while the controller is idle.
    assign o_stall = !w_idle;

    mstk_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_last_edge (i_last_edge),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_idle      (w_idle)
    );

    mstk_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_vertex_count   (r_vertex_count),
        .i_src_vertex     (i_src_vertex),
        .i_dst_vertex     (i_dst_vertex),
        .i_edge_weight    (i_edge_weight),
        .i_stall          (i_stall),
        .o_status         (w_status),
        .o_valid          (o_valid),
        .o_out_src_vertex (o_out_src_vertex),
        .o_out_dst_vertex (o_out_dst_vertex),
        .o_out_weight     (o_out_weight),
        .o_edge_present   (o_edge_present),
        .o_last_result    (o_last_result),
        .o_spanning       (o_spanning),
        .o_edges_dropped  (o_edges_dropped)
    );

    // Summary flags appear only on the final word of a run.
    `MSTK_ASSERT_SAME(a_flags_on_last, i_clk, i_rst_n, o_valid && !o_last_result, !o_spanning && !o_edges_dropped)
    // A word without an edge is always the final word of its run.
    `MSTK_ASSERT_SAME(a_empty_is_last, i_clk, i_rst_n, o_valid && !o_edge_present, o_last_result)
    // The last edge starts a run, which blocks further input.
    `MSTK_ASSERT_NEXT(a_run_blocks_input, i_clk, i_rst_n, i_valid && !o_stall && i_last_edge, o_stall)

endmodule

`default_nettype wire

FILE: src/mstk_ctrl.sv
// ----------------------------------------------------------------------------
// mstk_ctrl
// Sequencer for loading, sorted scanning, root search and result pushing.
// ----------------------------------------------------------------------------
`default_nettype none

module mstk_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic             i_last_edge,
    input  wire mstk_pkg::t_status i_status,
    output mstk_pkg::t_cmd        o_cmd,
    output logic                  o_idle
);

    mstk_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mstk_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_idle  = 1'b0;
        unique case (r_state)
            mstk_pkg::S_IDLE: begin
                o_idle = 1'b1;
                if (i_valid) begin
                    o_cmd.load_en = 1'b1;
                    if (i_last_edge) begin
                        n_state = mstk_pkg::S_INIT;
                    end
                end
            end
            mstk_pkg::S_INIT: begin
                o_cmd.run_init = 1'b1;
                n_state        = mstk_pkg::S_CHECK;
            end
            mstk_pkg::S_CHECK: begin
                if (i_status.tree_full) begin
                    n_state = mstk_pkg::S_FINISH;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = mstk_pkg::S_SCAN;
                end
            end
            mstk_pkg::S_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_status.scan_done) begin
                    if (i_status.found) begin
                        o_cmd.take_best = 1'b1;
                        n_state         = mstk_pkg::S_FIND_A;
                    end else begin
                        n_state = mstk_pkg::S_FINISH;
                    end
                end
            end
            mstk_pkg::S_FIND_A: begin
                if (i_status.at_root) begin
                    o_cmd.switch_b = 1'b1;
                    n_state        = mstk_pkg::S_FIND_B;
                end else begin
                    o_cmd.walk = 1'b1;
                end
            end
            mstk_pkg::S_FIND_B: begin
                if (i_status.at_root) begin
                    n_state = i_status.roots_differ ? mstk_pkg::S_JOIN : mstk_pkg::S_CHECK;
                end else begin
                    o_cmd.walk = 1'b1;
                end
            end
            mstk_pkg::S_JOIN: begin
                if (!i_status.hold_valid || i_status.out_free) begin
                    o_cmd.join_sets = 1'b1;
                    n_state         = mstk_pkg::S_CHECK;
                end
            end
            mstk_pkg::S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = mstk_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mstk_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: src/mstk_dp.sv
// ----------------------------------------------------------------------------
// mstk_dp
// Edge store, minimum-key scan, union-find walk and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mstk_dp (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire mstk_pkg::t_cmd                          i_cmd,
    input  wire logic [mstk_pkg::VC_W-1:0]               i_vertex_count,
    input  wire logic [mstk_pkg::VTX_W-1:0]              i_src_vertex,
    input  wire logic [mstk_pkg::VTX_W-1:0]              i_dst_vertex,
    input  wire logic signed [mstk_pkg::WEIGHT_BITS-1:0] i_edge_weight,
    input  wire logic                                    i_stall,
    output mstk_pkg::t_status                            o_status,
    output logic                                         o_valid,
    output logic [mstk_pkg::VTX_W-1:0]                   o_out_src_vertex,
    output logic [mstk_pkg::VTX_W-1:0]                   o_out_dst_vertex,
    output logic signed [mstk_pkg::WEIGHT_BITS-1:0]      o_out_weight,
    output logic                                         o_edge_present,
    output logic                                         o_last_result,
    output logic                                         o_spanning,
    output logic                                         o_edges_dropped
);

    // Vertices in use, clamped to 1..MAX_VERTICES.
    logic [mstk_pkg::N_W-1:0] w_n;
    always_comb begin
        if (i_vertex_count == '0) begin
            w_n = mstk_pkg::N_W'(1);
        end else if ({1'b0, i_vertex_count} > (mstk_pkg::VC_W + 1)'(mstk_pkg::MAX_VERTICES)) begin
            w_n = mstk_pkg::N_W'(mstk_pkg::MAX_VERTICES);
        end else begin
            w_n = mstk_pkg::N_W'(i_vertex_count);
        end
    end

    // Edge store and load.
    mstk_pkg::t_edge                r_mem [mstk_pkg::MAX_EDGES];
    mstk_pkg::t_edge                r_rd;
    logic [mstk_pkg::ECNT_W-1:0]    r_edge_count;
    logic                           r_drop;
    logic [mstk_pkg::ECNT_W-1:0]    r_scan_idx;
    logic                           w_load_ok;
    logic                           w_mem_wr;

    assign w_load_ok = ({1'b0, i_src_vertex} < w_n) && ({1'b0, i_dst_vertex} < w_n)
                       && (r_edge_count < mstk_pkg::ECNT_W'(mstk_pkg::MAX_EDGES));
    assign w_mem_wr  = i_cmd.load_en && w_load_ok;

    always_ff @(posedge i_clk) begin
        if (w_mem_wr) begin
            r_mem[r_edge_count[mstk_pkg::EIDX_W-1:0]] <= '{src: i_src_vertex,
                                                           dst: i_dst_vertex,
                                                           w:   i_edge_weight};
        end
        r_rd <= r_mem[r_scan_idx[mstk_pkg::EIDX_W-1:0]];
    end

    // Scan for the smallest (weight, index) key above the previous one.
    logic                              r_rd_vld;
    logic [mstk_pkg::EIDX_W-1:0]       r_rd_idx;
    mstk_pkg::t_edge                   r_best;
    logic [mstk_pkg::EIDX_W-1:0]       r_best_idx;
    logic                              r_found;
    logic signed [mstk_pkg::WEIGHT_BITS-1:0] r_prev_w;
    logic [mstk_pkg::EIDX_W-1:0]       r_prev_idx;
    logic                              r_prev_vld;
    logic                              w_after_prev;
    logic                              w_better;

    assign w_after_prev = !r_prev_vld || (r_rd.w > r_prev_w)
                          || ((r_rd.w == r_prev_w) && (r_rd_idx > r_prev_idx));
    assign w_better     = !r_found || (r_rd.w < r_best.w);

    // Union-find: a vertex without a valid parent is its own root.
    logic [mstk_pkg::VTX_W-1:0] r_par [mstk_pkg::MAX_VERTICES];
    logic [mstk_pkg::MAX_VERTICES-1:0] r_par_vld;
    logic [mstk_pkg::VTX_W-1:0] r_cur;
    logic [mstk_pkg::VTX_W-1:0] r_ra;
    logic [mstk_pkg::VTX_W-1:0] r_tree;
    mstk_pkg::t_edge            r_hold;
    logic                       r_hold_vld;
    logic                       w_out_free;

    assign w_out_free = !o_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk) begin
            r_cur <= r_par[r_cur];
        end else if (i_cmd.take_best) begin
            r_cur <= r_best.src;
        end else if (i_cmd.switch_b) begin
            r_cur <= r_best.dst;
        end
        if (i_cmd.switch_b) begin
            r_ra <= r_cur;
        end
        if (i_cmd.join_sets) begin
            r_par[r_ra] <= r_cur;
            r_hold      <= r_best;
        end
        if (i_cmd.take_best) begin
            r_prev_w   <= r_best.w;
            r_prev_idx <= r_best_idx;
        end
        if (i_cmd.scan_run && (r_scan_idx < r_edge_count)) begin
            r_rd_idx <= r_scan_idx[mstk_pkg::EIDX_W-1:0];
        end
        if (r_rd_vld && w_after_prev && w_better) begin
            r_best     <= r_rd;
            r_best_idx <= r_rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_count <= '0;
            r_drop       <= 1'b0;
            r_scan_idx   <= '0;
            r_rd_vld     <= 1'b0;
            r_found      <= 1'b0;
            r_prev_vld   <= 1'b0;
            r_par_vld    <= '0;
            r_tree       <= '0;
            r_hold_vld   <= 1'b0;
            o_valid      <= 1'b0;
        end else begin
            if (i_cmd.load_en) begin
                if (w_load_ok) begin
                    r_edge_count <= r_edge_count + 1'b1;
                end else begin
                    r_drop <= 1'b1;
                end
            end
            if (i_cmd.scan_start) begin
                r_scan_idx <= '0;
                r_rd_vld   <= 1'b0;
                r_found    <= 1'b0;
            end else if (i_cmd.scan_run) begin
                if (r_scan_idx < r_edge_count) begin
                    r_scan_idx <= r_scan_idx + 1'b1;
                    r_rd_vld   <= 1'b1;
                end else begin
                    r_rd_vld <= 1'b0;
                end
                if (r_rd_vld && w_after_prev && w_better) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.take_best) begin
                r_prev_vld <= 1'b1;
            end
            if (i_cmd.run_init) begin
                r_par_vld  <= '0;
                r_tree     <= '0;
                r_prev_vld <= 1'b0;
                r_hold_vld <= 1'b0;
            end
            if (i_cmd.join_sets) begin
                r_par_vld[r_ra] <= 1'b1;
                r_tree          <= r_tree + 1'b1;
                r_hold_vld      <= 1'b1;
            end
            if (i_cmd.finish) begin
                r_edge_count <= '0;
                r_drop       <= 1'b0;
            end
            if ((i_cmd.join_sets && r_hold_vld) || i_cmd.finish) begin
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    // Output word register; a word moves here only when the slot is free.
    always_ff @(posedge i_clk) begin
        if (i_cmd.join_sets && r_hold_vld) begin
            o_out_src_vertex <= r_hold.src;
            o_out_dst_vertex <= r_hold.dst;
            o_out_weight     <= r_hold.w;
            o_edge_present   <= 1'b1;
            o_last_result    <= 1'b0;
            o_spanning       <= 1'b0;
            o_edges_dropped  <= 1'b0;
        end else if (i_cmd.finish) begin
            o_out_src_vertex <= r_hold_vld ? r_hold.src : '0;
            o_out_dst_vertex <= r_hold_vld ? r_hold.dst : '0;
            o_out_weight     <= r_hold_vld ? r_hold.w : '0;
            o_edge_present   <= r_hold_vld;
            o_last_result    <= 1'b1;
            o_spanning       <= (mstk_pkg::N_W'(r_tree) + 1'b1) == w_n;
            o_edges_dropped  <= r_drop;
        end
    end

    always_comb begin
        o_status.scan_done    = (r_scan_idx == r_edge_count) && !r_rd_vld;
        o_status.found        = r_found;
        o_status.at_root      = !r_par_vld[r_cur];
        o_status.roots_differ = r_ra != r_cur;
        o_status.tree_full    = (mstk_pkg::N_W'(r_tree) + 1'b1) >= w_n;
        o_status.hold_valid   = r_hold_vld;
        o_status.out_free     = w_out_free;
    end

endmodule

`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Kruskal spanning tree block testbench
// Loads edge graphs under several vertex_count settings and compares every
// output word against a behavioral prediction of the tree or a hand-written
// result, with random gaps on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
    import mstk_pkg::*;

    localparam int          WATCHDOG_LIMIT   = 40000;
    localparam logic [2:0]  REG_VERTEX_COUNT = 3'd0;
    localparam int          LONG_HOLD        = 600;
    localparam int          RANDOM_ITEMS     = 300;

    // One output word of the block.
    typedef struct {
        logic [VTX_W-1:0]              src;
        logic [VTX_W-1:0]              dst;
        logic signed [WEIGHT_BITS-1:0] w;
        logic                          present;
        logic                          last;
        logic                          spanning;
        logic                          dropped;
    } tree_word_t;

    // One directed row: the vertex_count it runs under, the edge, and an
    // optional hand-written result for rows whose outcome is obvious.
    typedef struct {
        logic [5:0]                    vc;
        logic [VTX_W-1:0]              src;
        logic [VTX_W-1:0]              dst;
        logic signed [WEIGHT_BITS-1:0] w;
        logic                          last;
        logic                          typed;
        tree_word_t                    want;
    } edge_row_t;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_stall;
    logic [VTX_W-1:0]              i_src_vertex;
    logic [VTX_W-1:0]              i_dst_vertex;
    logic signed [WEIGHT_BITS-1:0] i_edge_weight;
    logic                          i_last_edge;
    logic                          o_valid;
    logic                          i_stall;
    logic [VTX_W-1:0]              o_out_src_vertex;
    logic [VTX_W-1:0]              o_out_dst_vertex;
    logic signed [WEIGHT_BITS-1:0] o_out_weight;
    logic                          o_edge_present;
    logic                          o_last_result;
    logic                          o_spanning;
    logic                          o_edges_dropped;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [2:0]                    paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;

    minimum_spanning_tree_kruskal u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_src_vertex     (i_src_vertex),
        .i_dst_vertex     (i_dst_vertex),
        .i_edge_weight    (i_edge_weight),
        .i_last_edge      (i_last_edge),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_out_src_vertex (o_out_src_vertex),
        .o_out_dst_vertex (o_out_dst_vertex),
        .o_out_weight     (o_out_weight),
        .o_edge_present   (o_edge_present),
        .o_last_result    (o_last_result),
        .o_spanning       (o_spanning),
        .o_edges_dropped  (o_edges_dropped),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // ------------------------------------------------------------------------
    // Shadow state of the block: the loaded graph, the union-find and the
    // vertex_count register as last written.
    // ------------------------------------------------------------------------
    logic [VTX_W-1:0]              graph_src [MAX_EDGES];
    logic [VTX_W-1:0]              graph_dst [MAX_EDGES];
    logic signed [WEIGHT_BITS-1:0] graph_w   [MAX_EDGES];
    int                            graph_len;
    logic                          graph_dropped;
    int                            uf_parent [MAX_VERTICES];
    int                            uf_rank   [MAX_VERTICES];
    logic [5:0]                    vertex_reg;

    tree_word_t tree_words_due[$];
    int         mismatches;
    int         idle_cycles;
    logic       hold_request;

    function automatic int find_root(int v);
        int r;
        int nxt;
        r = v;
        while (uf_parent[r] != r) r = uf_parent[r];
        // Path compression: point the whole chain at the root.
        while (uf_parent[v] != r) begin
            nxt = uf_parent[v];
            uf_parent[v] = r;
            v = nxt;
        end
        return r;
    endfunction

    // Takes one accepted edge and returns the words it makes the block emit.
    task automatic grow_tree(input logic [VTX_W-1:0] s, input logic [VTX_W-1:0] d,
                             input logic signed [WEIGHT_BITS-1:0] w, input logic last,
                             output tree_word_t words[$]);
        int         n;
        int         order [MAX_EDGES];
        int         i;
        int         j;
        int         ra;
        int         rb;
        int         chosen;
        tree_word_t tw;
        words = {};
        n = (vertex_reg == 0) ? 1 : (vertex_reg > MAX_VERTICES) ? MAX_VERTICES : vertex_reg;
        if (s >= n || d >= n || graph_len >= MAX_EDGES) begin
            graph_dropped = 1'b1;
        end else begin
            graph_src[graph_len] = s;
            graph_dst[graph_len] = d;
            graph_w[graph_len]   = w;
            graph_len++;
        end
        if (!last) return;
        // Stable insertion sort by weight keeps ties in arrival order.
        for (i = 0; i < graph_len; i++) begin
            j = i;
            while (j > 0 && graph_w[order[j-1]] > graph_w[i]) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = i;
        end
        for (i = 0; i < MAX_VERTICES; i++) begin
            uf_parent[i] = i;
            uf_rank[i]   = 0;
        end
        chosen = 0;
        for (i = 0; i < graph_len && chosen + 1 < n; i++) begin
            ra = find_root(graph_src[order[i]]);
            rb = find_root(graph_dst[order[i]]);
            if (ra != rb) begin
                tw = '{graph_src[order[i]], graph_dst[order[i]], graph_w[order[i]],
                       1'b1, 1'b0, 1'b0, 1'b0};
                words.push_back(tw);
                chosen++;
                if (uf_rank[ra] < uf_rank[rb]) begin
                    uf_parent[ra] = rb;
                end else if (uf_rank[ra] > uf_rank[rb]) begin
                    uf_parent[rb] = ra;
                end else begin
                    uf_parent[rb] = ra;
                    uf_rank[ra]++;
                end
            end
        end
        // With nothing chosen the block still emits one empty word.
        if (words.size() == 0) begin
            tw = '{'0, '0, '0, 1'b0, 1'b0, 1'b0, 1'b0};
            words.push_back(tw);
        end
        tw = words.pop_back();
        tw.last     = 1'b1;
        tw.spanning = (chosen + 1 == n);
        tw.dropped  = graph_dropped;
        words.push_back(tw);
        graph_len     = 0;
        graph_dropped = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Clock, reset and watchdog.
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Any accepted word on either channel counts as progress.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d words still due", $time,
                     tree_words_due.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Output side: random stall with one long hold-off on request, and the
    // word checker sampling at the rising edge.
    // ------------------------------------------------------------------------
    initial begin : stall_driver
        int hold;
        int pick;
        hold = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_stall <= 1'b1;
                hold = LONG_HOLD;
            end else if (hold > 0) begin
                hold--;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    i_stall <= 1'b0;
                    hold = $urandom_range(0, 6);
                end else if (pick < 95) begin
                    i_stall <= 1'b1;
                    hold = $urandom_range(0, 3);
                end else begin
                    i_stall <= 1'b1;
                    hold = $urandom_range(10, 40);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        tree_word_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (tree_words_due.size() == 0) begin
                $display("%0t: unexpected word src=%0d dst=%0d w=%0d", $time,
                         o_out_src_vertex, o_out_dst_vertex, o_out_weight);
                mismatches++;
            end else begin
                want = tree_words_due.pop_front();
                if (o_out_src_vertex !== want.src || o_out_dst_vertex !== want.dst ||
                    o_out_weight !== want.w || o_edge_present !== want.present ||
                    o_last_result !== want.last || o_spanning !== want.spanning ||
                    o_edges_dropped !== want.dropped) begin
                    $display("%0t: expected src=%0d dst=%0d w=%0d pres=%b last=%b span=%b drop=%b",
                             $time, want.src, want.dst, want.w, want.present, want.last,
                             want.spanning, want.dropped);
                    $display("%0t: actual   src=%0d dst=%0d w=%0d pres=%b last=%b span=%b drop=%b",
                             $time, o_out_src_vertex, o_out_dst_vertex, o_out_weight,
                             o_edge_present, o_last_result, o_spanning, o_edges_dropped);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input side.
    // ------------------------------------------------------------------------

    // Offers one edge after an optional gap and returns once it is accepted.
    // A typed expectation, when given, replaces the predicted words.
    task automatic offer_edge(input logic [VTX_W-1:0] s, input logic [VTX_W-1:0] d,
                              input logic signed [WEIGHT_BITS-1:0] w, input logic last,
                              input logic typed, input tree_word_t want);
        int         gap;
        int         pick;
        tree_word_t words[$];
        pick = $urandom_range(0, 99);
        gap = (pick < 60) ? 0 : (pick < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_src_vertex  <= s;
        i_dst_vertex  <= d;
        i_edge_weight <= w;
        i_last_edge   <= last;
        do @(posedge i_clk); while (o_stall);
        grow_tree(s, d, w, last, words);
        if (typed) begin
            tree_words_due.push_back(want);
        end else begin
            foreach (words[k]) tree_words_due.push_back(words[k]);
        end
    endtask

    // Waits for the block to drain, then writes vertex_count over APB.
    task automatic set_vertex_count(input logic [5:0] vc);
        @(negedge i_clk);
        i_valid <= 1'b0;
        wait (tree_words_due.size() == 0);
        repeat (20) @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= REG_VERTEX_COUNT;
        pwdata  <= {26'd0, vc};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        vertex_reg = vc;
    endtask

    // Directed rows. Rows with a hand-written result cover the empty tree,
    // a single vertex, dropped edges and the zero register value.
    edge_row_t directed_rows[] = '{
        '{6'd32, 5'd0,  5'd31, -16'sd32768, 1'b0, 1'b0, '{0,0,0,0,0,0,0}},
        '{6'd32, 5'd31, 5'd0,   16'sd32767, 1'b0, 1'b0, '{0,0,0,0,0,0,0}},
        '{6'd32, 5'd5,  5'd5,   16'sd0,     1'b0, 1'b0, '{0,0,0,0,0,0,0}},
        '{6'd32, 5'd1,  5'd2,   16'sd100,   1'b0, 1'b0, '{0,0,0,0,0,0,0}},
        '{6'd32, 5'd2,  5'd3,   16'sd100,   1'b0, 1'b0, '{0,0,0,0,0,0,0}},
        '{6'd32, 5'd1,  5'd3,   16'sd100,   1'b0, 1'b0, '{0,0,0,0,0,0,0}},
        '{6'd32, 5'd31, 5'd30, -16'sd1,     1'b1, 1'b0, '{0,0,0,0,0,0,0}},
        '{6'd32, 5'd3,  5'd3,   16'sd7,     1'b1, 1'b1, '{0,0,0,0,1,0,0}},
        '{6'd1,  5'd0,  5'd0,   16'sd5,     1'b1, 1'b1, '{0,0,0,0,1,1,0}},
        '{6'd1,  5'd1,  5'd0,   16'sd3,     1'b1, 1'b1, '{0,0,0,0,1,1,1}},
        '{6'd0,  5'd0,  5'd31,  16'sd9,     1'b1, 1'b1, '{0,0,0,0,1,1,1}},
        '{6'd2,  5'd1,  5'd0,  -16'sd5,     1'b1, 1'b1, '{1,0,-5,1,1,1,0}},
        '{6'd63, 5'd31, 5'd0,   16'sd1,     1'b0, 1'b0, '{0,0,0,0,0,0,0}},
        '{6'd63, 5'd30, 5'd31,  16'sd2,     1'b1, 1'b0, '{0,0,0,0,0,0,0}}
    };

    initial begin : stimulus
        int         sent;
        int         graphs;
        int         graph_size;
        int         n;
        int         pick;
        logic [5:0] vc;
        logic [VTX_W-1:0] s;
        logic [VTX_W-1:0] d;
        tree_word_t none;
        none = '{0, 0, 0, 0, 0, 0, 0};
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_src_vertex  = '0;
        i_dst_vertex  = '0;
        i_edge_weight = '0;
        i_last_edge   = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        mismatches    = 0;
        idle_cycles   = 0;
        hold_request  = 1'b0;
        graph_len     = 0;
        graph_dropped = 1'b0;
        vertex_reg    = 6'd32;
        vc            = 6'd32;
        for (int v = 0; v < MAX_VERTICES; v++) begin
            uf_parent[v] = v;
            uf_rank[v]   = 0;
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part; the first rows run under the reset value of 32.
        foreach (directed_rows[r]) begin
            if (directed_rows[r].vc != vertex_reg) set_vertex_count(directed_rows[r].vc);
            offer_edge(directed_rows[r].src, directed_rows[r].dst, directed_rows[r].w,
                       directed_rows[r].last, directed_rows[r].typed, directed_rows[r].want);
        end

        // Random graphs. Most are small and well formed; some carry
        // out-of-range endpoints and a few overflow the edge store.
        sent   = 0;
        graphs = 0;
        while (sent < RANDOM_ITEMS) begin
            // The second random graph keeps the first one's vertex_count, so
            // its edges are offered at once while the first run sits behind
            // the long output hold-off and the block stalls its input.
            if (graphs != 1) begin
                pick = $urandom_range(0, 9);
                vc = (pick == 0) ? 6'($urandom_range(0, 63)) :
                     (pick == 1) ? 6'd32 : 6'($urandom_range(2, 32));
                set_vertex_count(vc);
            end
            n = (vc == 0) ? 1 : (vc > MAX_VERTICES) ? MAX_VERTICES : vc;
            pick = $urandom_range(0, 19);
            graph_size = (pick == 0) ? $urandom_range(60, 70) : $urandom_range(1, 14);
            // The long output hold-off starts with the first random graph.
            if (graphs == 0) hold_request = 1'b1;
            for (int e = 0; e < graph_size; e++) begin
                if ($urandom_range(0, 9) == 0) begin
                    s = VTX_W'($urandom);
                    d = VTX_W'($urandom);
                end else begin
                    s = VTX_W'($urandom_range(0, n - 1));
                    d = VTX_W'($urandom_range(0, n - 1));
                end
                // Narrow weights give plenty of ties; wide ones reach every bit.
                offer_edge(s, d, ($urandom_range(0, 1) == 1) ?
                           WEIGHT_BITS'($urandom) : WEIGHT_BITS'($urandom_range(0, 7)),
                           e == graph_size - 1, 1'b0, none);
                sent++;
            end
            graphs++;
        end
        @(negedge i_clk);
        i_valid <= 1'b0;

        wait (tree_words_due.size() == 0);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

FILE: sim.f
+incdir+src
src/mstk_pkg.sv
src/mstk_ctrl.sv
src/mstk_dp.sv
src/minimum_spanning_tree_kruskal.sv
bench/testbench.sv
